// ===== sv/fsa_pkg.sv =====
package fsa_pkg;

	localparam int CFG_W   = 11;
	localparam int GUARD_W = 3;
	localparam int TAIL_W  = 4;
	localparam int START_W = 11;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_ACTIVE_SLOTS  = 2'd0;
	localparam reg_idx_t REG_GUARD_RADIUS  = 2'd1;
	localparam reg_idx_t REG_TAIL_RESERVED = 2'd2;

	localparam logic ACT_CLEAR = 1'b0;

	localparam logic [CFG_W-1:0]   ACTIVE_RST = 11'd1024;
	localparam logic [GUARD_W-1:0] GUARD_RST  = 3'd2;
	localparam logic [TAIL_W-1:0]  TAIL_RST   = 4'd2;

endpackage

// ===== sv/next_free_slot_allocator_with_guard_unit.sv =====
// Slot allocator with guard band. The occupancy map lives in a word-wide RAM
// (up to 32 slots per word) with a per-word free flag and valid bit in flops;
// the flags steer the search to candidate words. A request steps through the
// find, check, win and mark states when the first candidate word holds the
// grant; each candidate word that holds nothing usable sends it back through
// find and check, a guard window that crosses into a neighbor word adds a
// second mark state (one extra RAM read-modify-write), and the wrap pass adds
// another find. A clear sweeps the RAM one word per cycle. The done flag is
// high for exactly one cycle and cannot be held off; a new start is taken then.
module next_free_slot_allocator_with_guard_unit #(
	parameter int SLOTS = 1024,
	localparam int SW   = $clog2(SLOTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  fsa_pkg::reg_idx_t           cfg_addr,
	input  logic [fsa_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        start,
	input  logic                        action,
	input  logic [fsa_pkg::START_W-1:0] start_pos,
	output logic                        busy,
	output logic                        done,
	output logic                        found,
	output logic [SW-1:0]               slot
);

	import fsa_pkg::*;

	localparam int WB = (SLOTS < 32) ? SLOTS : 32;
	localparam int LB = $clog2(WB);
	localparam int NW = (SLOTS + WB - 1) / WB;
	localparam int WA = (NW > 1) ? $clog2(NW) : 1;
	localparam int CW = ((SW > CFG_W) ? SW : CFG_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_CLEAR, S_FIND, S_CHECK, S_WIN, S_MARK, S_MARK2
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   active_q;
	logic [GUARD_W-1:0] guard_q;
	logic [TAIL_W-1:0]  tail_q;
	logic [CW-1:0]      lo_q, s_q, glo_q, ghi_q, lf_q;
	logic               wrap_q;
	logic [WA-1:0]      w_q, nb_q, cnt_q;
	logic [WB-1:0]      d_q;
	logic [NW-1:0]      free_q, valid_q;
	logic               done_q, found_q;
	logic [SW-1:0]      slot_q;

	logic [CW-1:0] n_eff, start_ext, st1, lo_b, lim, tail_ext, g_ext, s_plus;
	logic [WA-1:0] lo_word, hit_word, rd_w, glo_w, ghi_w, nb_sel;
	logic          hit, nb_need, fhit;
	logic [WB-1:0] rdata, rd_word, free_vec, m_main, m_nb, clr_word;
	logic [LB-1:0] fidx;
	logic [WB-1:0] wr_data;
	logic [WA-1:0] wr_addr, rd_addr;
	logic          wr_en, rd_en;

	always_comb begin
		lim       = CW'(SLOTS);
		n_eff     = (CW'(active_q) > lim) ? lim : CW'(active_q);
		start_ext = CW'(start_pos);
		st1       = (start_ext == '0) ? CW'(1) : start_ext;
		lo_b      = lo_q - CW'(1);
		lo_word   = WA'(lo_b >> LB);
		tail_ext  = CW'(tail_q);
		g_ext     = CW'(guard_q);
		s_plus    = s_q + g_ext;
		rd_w      = (state_q == S_MARK2) ? nb_q : w_q;
		rd_word   = valid_q[rd_w] ? rdata : '1;
		glo_w     = WA'((glo_q - CW'(1)) >> LB);
		ghi_w     = WA'((ghi_q - CW'(1)) >> LB);
		nb_need   = (glo_w != w_q) || (ghi_w != w_q);
		nb_sel    = (glo_w != w_q) ? glo_w : ghi_w;
	end

	always_comb begin
		logic [CW-1:0] sl;
		for (int j = 0; j < WB; j++) begin
			sl          = (CW'(w_q) << LB) + CW'(j) + CW'(1);
			free_vec[j] = !rd_word[j] && (sl >= lo_q) && (sl <= n_eff);
			m_main[j]   = (sl >= glo_q) && (sl <= ghi_q);
			sl          = (CW'(nb_q) << LB) + CW'(j) + CW'(1);
			m_nb[j]     = (sl >= glo_q) && (sl <= ghi_q);
			sl          = (CW'(cnt_q) << LB) + CW'(j) + CW'(1);
			clr_word[j] = !(sl <= lf_q);
		end
	end

	always_comb begin
		fhit = 1'b0;
		fidx = '0;
		for (int j = WB - 1; j >= 0; j--) begin
			if (free_vec[j]) begin
				fhit = 1'b1;
				fidx = LB'(j);
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = w_q;
		wr_data = d_q | m_main;
		rd_en   = 1'b0;
		rd_addr = hit_word;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = clr_word;
			end
			S_FIND: begin
				rd_en = (lo_q <= n_eff) && hit;
			end
			S_MARK: begin
				wr_en   = 1'b1;
				rd_en   = nb_need;
				rd_addr = nb_sel;
			end
			S_MARK2: begin
				wr_en   = 1'b1;
				wr_addr = nb_q;
				wr_data = rd_word | m_nb;
			end
			default: ;
		endcase
	end

	fsa_word_scan #(.NW(NW), .WA(WA)) u_scan (
		.has_free  (free_q),
		.from_word (lo_word),
		.hit       (hit),
		.hit_word  (hit_word)
	);

	fsa_map_ram #(.NW(NW), .WB(WB), .WA(WA)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RST;
			guard_q  <= GUARD_RST;
			tail_q   <= TAIL_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ACTIVE_SLOTS:  active_q <= cfg_wdata;
				REG_GUARD_RADIUS:  guard_q  <= cfg_wdata[GUARD_W-1:0];
				REG_TAIL_RESERVED: tail_q   <= cfg_wdata[TAIL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q  <= '0;
			valid_q <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			slot_q  <= '0;
			wrap_q  <= 1'b0;
			cnt_q   <= '0;
			lo_q    <= '0;
			s_q     <= '0;
			glo_q   <= '0;
			ghi_q   <= '0;
			lf_q    <= '0;
			w_q     <= '0;
			nb_q    <= '0;
			d_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				free_q[wr_addr]  <= ~&wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (action == ACT_CLEAR) begin
							lf_q    <= (tail_ext >= n_eff) ? '0 : n_eff - tail_ext;
							cnt_q   <= '0;
							state_q <= S_CLEAR;
						end else if (n_eff == '0) begin
							done_q  <= 1'b1;
							found_q <= 1'b0;
							slot_q  <= '0;
						end else begin
							if (st1 <= n_eff) begin
								lo_q   <= st1;
								wrap_q <= 1'b0;
							end else begin
								lo_q   <= CW'(1);
								wrap_q <= 1'b1;
							end
							state_q <= S_FIND;
						end
					end
				end
				S_CLEAR: begin
					if (cnt_q == WA'(NW - 1)) begin
						done_q  <= 1'b1;
						found_q <= 1'b0;
						slot_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + WA'(1);
					end
				end
				S_FIND: begin
					if ((lo_q <= n_eff) && hit) begin
						w_q     <= hit_word;
						state_q <= S_CHECK;
					end else if (!wrap_q) begin
						lo_q   <= CW'(1);
						wrap_q <= 1'b1;
					end else begin
						done_q  <= 1'b1;
						found_q <= 1'b0;
						slot_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_CHECK: begin
					d_q <= rd_word;
					if (fhit) begin
						s_q     <= (CW'(w_q) << LB) + CW'(fidx) + CW'(1);
						state_q <= S_WIN;
					end else begin
						lo_q    <= ((CW'(w_q) + CW'(1)) << LB) + CW'(1);
						state_q <= S_FIND;
					end
				end
				S_WIN: begin
					glo_q   <= (s_q > g_ext) ? s_q - g_ext : CW'(1);
					ghi_q   <= (s_plus > n_eff) ? n_eff : s_plus;
					state_q <= S_MARK;
				end
				S_MARK: begin
					if (nb_need) begin
						nb_q    <= nb_sel;
						state_q <= S_MARK2;
					end else begin
						done_q  <= 1'b1;
						found_q <= 1'b1;
						slot_q  <= SW'(s_q);
						state_q <= S_IDLE;
					end
				end
				S_MARK2: begin
					done_q  <= 1'b1;
					found_q <= 1'b1;
					slot_q  <= SW'(s_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;
	assign found = found_q;
	assign slot  = slot_q;

endmodule

// ===== sv/fsa_map_ram.sv =====
module fsa_map_ram #(
	parameter int NW = 32,
	parameter int WB = 32,
	parameter int WA = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [WA-1:0] waddr,
	input  logic [WB-1:0] wdata,
	input  logic          re,
	input  logic [WA-1:0] raddr,
	output logic [WB-1:0] rdata
);

	logic [WB-1:0] mem [NW];
	logic [WB-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/fsa_word_scan.sv =====
module fsa_word_scan #(
	parameter int NW = 32,
	parameter int WA = 5
) (
	input  logic [NW-1:0] has_free,
	input  logic [WA-1:0] from_word,
	output logic          hit,
	output logic [WA-1:0] hit_word
);

	always_comb begin
		hit      = 1'b0;
		hit_word = '0;
		for (int i = NW - 1; i >= 0; i--) begin
			if (has_free[i] && (WA'(i) >= from_word)) begin
				hit      = 1'b1;
				hit_word = WA'(i);
			end
		end
	end

endmodule

// ===== sv/fsa_chk.sv =====
module fsa_chk #(
	parameter int SW = 11
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          action,
	input logic          done,
	input logic          found,
	input logic [SW-1:0] slot
);

	import fsa_pkg::*;

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> slot == '0)
		else $error("no-grant transfer with nonzero slot");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> slot != '0)
		else $error("grant transfer with slot zero");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_CLEAR) |=> busy)
		else $error("clear did not start sweep");

endmodule

bind next_free_slot_allocator_with_guard_unit fsa_chk #(.SW(SW)) u_fsa_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.action (action),
	.done   (done),
	.found  (found),
	.slot   (slot)
);
